[design/tfa_pkg.sv]
`timescale 1ns / 1ps
// Package for the texel to ARGB32 converter: codes, queue item type and
// the channel scaling functions shared by the front and back parts.
package tfa_pkg;

	localparam int PALETTE_DEPTH = 256;
	localparam int PAL_IDX_W = $clog2(PALETTE_DEPTH);
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] CMD_CONVERT = 2'd0;
	localparam logic [1:0] CMD_PAL_WRITE = 2'd1;
	localparam logic [1:0] CMD_PAL_CLEAR = 2'd2;

	localparam logic [1:0] REG_PIXEL_FORMAT = 2'd0;
	localparam logic [1:0] REG_PALETTE_FORMAT = 2'd1;

	localparam logic [2:0] PF_ARGB4444 = 3'd0;
	localparam logic [2:0] PF_ARGB1555 = 3'd1;
	localparam logic [2:0] PF_RGB565 = 3'd2;
	localparam logic [2:0] PF_BGR888 = 3'd3;
	localparam logic [2:0] PF_ARGB8888 = 3'd4;
	localparam logic [2:0] PF_INDEXED8 = 3'd5;

	localparam logic [1:0] PALF_ARGB8888 = 2'd0;
	localparam logic [1:0] PALF_RGB888 = 2'd1;
	localparam logic [1:0] PALF_ARGB1555 = 2'd2;
	localparam logic [1:0] PALF_RGB565 = 2'd3;

	localparam logic [15:0] TRANSPARENT_CODE = 16'h0001;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	typedef enum logic [2:0] {
		KIND_4444 = 3'd0,
		KIND_1555 = 3'd1,
		KIND_565 = 3'd2,
		KIND_888 = 3'd3,
		KIND_DIRECT = 3'd4
	} tfa_kind_t;

	typedef struct packed {
		tfa_kind_t kind;
		logic [31:0] value;
	} tfa_item_t;

	function automatic logic [7:0] scale5(input logic [4:0] x);
		logic [7:0] r;
		r = {x, 3'b000};
		r = r + {7'd0, x >= 5'd5} + {7'd0, x >= 5'd9} + {7'd0, x >= 5'd14}
			+ {7'd0, x >= 5'd18} + {7'd0, x >= 5'd23} + {7'd0, x >= 5'd27}
			+ {7'd0, x == 5'd31};
		return r;
	endfunction

	function automatic logic [7:0] scale6(input logic [5:0] x);
		logic [7:0] r;
		r = {x, 2'b00};
		r = r + {7'd0, x >= 6'd21} + {7'd0, x >= 6'd42} + {7'd0, x == 6'd63};
		return r;
	endfunction

	function automatic logic [31:0] conv4444(input logic [15:0] c);
		if (c == TRANSPARENT_CODE) begin
			return 32'd0;
		end
		return {c[15:12], c[15:12], c[11:8], c[11:8], c[7:4], c[7:4], c[3:0], c[3:0]};
	endfunction

	function automatic logic [31:0] conv1555(input logic [15:0] c);
		if (c == TRANSPARENT_CODE) begin
			return 32'd0;
		end
		return {{8{c[15]}}, scale5(c[14:10]), scale5(c[9:5]), scale5(c[4:0])};
	endfunction

	function automatic logic [31:0] conv565(input logic [15:0] c);
		if (c == TRANSPARENT_CODE) begin
			return 32'd0;
		end
		return {ALPHA_OPAQUE, scale5(c[15:11]), scale6(c[10:5]), scale5(c[4:0])};
	endfunction

	function automatic logic [31:0] gray(input logic [7:0] i);
		return {ALPHA_OPAQUE, i, i, i};
	endfunction

endpackage

[design/texel_format_to_argb32.sv]
`timescale 1ns / 1ps
// Top level of the texel to ARGB32 converter.
// Depends on tfa_pkg, tfa_front, tfa_queue and tfa_back.
//
// Items enter on the input channel (in_valid, in_stall) with cmd, data and
// entry_index. A convert item yields one argb result on the output channel
// (out_valid, out_stall); palette writes, palette clears and unknown
// commands yield none. The pixel and palette formats are set through the
// write port (cfg_write, cfg_index, cfg_data) while the block is idle.
// An item is taken every cycle while in_stall is low. A convert result
// passes the front register, where the palette RAM read completes, then
// a queue entry, then the output register. Palette writes and clears take
// effect at the edge that accepts them, so later items see them in order.
// When the receiver stalls, the output register holds its result, the
// two-entry queue fills, and in_stall rises once the front register is also
// occupied. Reset clears the formats, all palette loaded flags, the queue
// and both valid flags; no palette sweep is needed after reset.
module texel_format_to_argb32 import tfa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [31:0] data,
	input  logic [7:0]  entry_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] argb,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [2:0]  cfg_data
);

	logic push;
	logic pop;
	logic full;
	logic empty;
	tfa_item_t push_item;
	tfa_item_t pop_item;

	tfa_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.data(data),
		.entry_index(entry_index),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.push_item(push_item),
		.queue_full(full)
	);

	tfa_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.full(full),
		.pop(pop),
		.pop_item(pop_item),
		.empty(empty)
	);

	tfa_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_item(pop_item),
		.empty(empty),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.argb(argb)
	);

endmodule

[design/tfa_front.sv]
`timescale 1ns / 1ps
// Front part: accepts items, holds the configuration registers and the
// palette, and hands classified pixels to the queue. Uses tfa_pkg.
module tfa_front import tfa_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [1:0]      cmd,
	input  logic [31:0]     data,
	input  logic [7:0]      entry_index,
	input  logic            cfg_write,
	input  logic [1:0]      cfg_index,
	input  logic [2:0]      cfg_data,
	output logic            push,
	output tfa_item_t       push_item,
	input  logic            queue_full
);

	logic [2:0] pixel_format_q;
	logic [1:0] palette_format_q;
	logic [PALETTE_DEPTH-1:0] loaded_q;
	logic [31:0] pal_mem [PALETTE_DEPTH];

	logic valid_s1;
	tfa_kind_t kind_s1;
	logic [31:0] data_s1;
	logic pal_s1;
	logic hit_s1;
	logic [31:0] rdata_s1;

	logic accept;
	logic do_convert;
	logic do_write;
	logic do_clear;
	logic wr_in_range;
	logic rd_in_range;
	logic [31:0] wr_value;
	tfa_kind_t kind_in;

	assign in_stall = valid_s1 && queue_full;
	assign accept = in_valid && !in_stall;
	assign do_convert = accept && (cmd == CMD_CONVERT);
	assign do_write = accept && (cmd == CMD_PAL_WRITE);
	assign do_clear = accept && (cmd == CMD_PAL_CLEAR);
	assign wr_in_range = {1'b0, entry_index} < 9'(PALETTE_DEPTH);
	assign rd_in_range = {1'b0, data[7:0]} < 9'(PALETTE_DEPTH);

	always_comb begin
		case (palette_format_q)
			PALF_ARGB8888: wr_value = data;
			PALF_RGB888: wr_value = {ALPHA_OPAQUE, data[7:0], data[15:8], data[23:16]};
			PALF_ARGB1555: wr_value = conv1555(data[15:0]);
			default: wr_value = conv565(data[15:0]);
		endcase
	end

	always_comb begin
		case (pixel_format_q)
			PF_ARGB4444: kind_in = KIND_4444;
			PF_ARGB1555: kind_in = KIND_1555;
			PF_BGR888: kind_in = KIND_888;
			PF_ARGB8888: kind_in = KIND_DIRECT;
			PF_INDEXED8: kind_in = KIND_DIRECT;
			default: kind_in = KIND_565;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q <= PF_ARGB4444;
			palette_format_q <= PALF_ARGB8888;
		end else if (cfg_write) begin
			if (cfg_index == REG_PIXEL_FORMAT) begin
				pixel_format_q <= cfg_data;
			end else if (cfg_index == REG_PALETTE_FORMAT) begin
				palette_format_q <= cfg_data[1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
		end else if (do_clear) begin
			loaded_q <= '0;
		end else if (do_write && wr_in_range) begin
			loaded_q[entry_index[PAL_IDX_W-1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_write && wr_in_range) begin
			pal_mem[entry_index[PAL_IDX_W-1:0]] <= wr_value;
		end
		if (do_convert) begin
			rdata_s1 <= pal_mem[data[PAL_IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (do_convert) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_convert) begin
			kind_s1 <= kind_in;
			data_s1 <= data;
			pal_s1 <= (pixel_format_q == PF_INDEXED8);
			hit_s1 <= rd_in_range && loaded_q[data[PAL_IDX_W-1:0]];
		end
	end

	assign push = valid_s1 && !queue_full;

	always_comb begin
		push_item.kind = kind_s1;
		if (pal_s1) begin
			push_item.value = hit_s1 ? rdata_s1 : gray(data_s1[7:0]);
		end else begin
			push_item.value = data_s1;
		end
	end

endmodule

[design/tfa_queue.sv]
`timescale 1ns / 1ps
// Short queue that decouples the front part from the back part.
// Uses tfa_pkg for the item type and depth.
module tfa_queue import tfa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  tfa_item_t  push_item,
	output logic       full,
	input  logic       pop,
	output tfa_item_t  pop_item,
	output logic       empty
);

	tfa_item_t entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	assign full = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign pop_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/tfa_back.sv]
`timescale 1ns / 1ps
// Back part: expands queued pixels to ARGB8888 into the output register.
// Uses tfa_pkg for the item type and conversion functions.
module tfa_back import tfa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  tfa_item_t   pop_item,
	input  logic        empty,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] argb
);

	logic valid_q;
	logic [31:0] argb_q;
	logic [31:0] conv_value;

	assign pop = !empty && (!valid_q || !out_stall);
	assign out_valid = valid_q;
	assign argb = argb_q;

	always_comb begin
		case (pop_item.kind)
			KIND_4444: conv_value = conv4444(pop_item.value[15:0]);
			KIND_1555: conv_value = conv1555(pop_item.value[15:0]);
			KIND_565: conv_value = conv565(pop_item.value[15:0]);
			KIND_888: conv_value = {ALPHA_OPAQUE, pop_item.value[23:0]};
			default: conv_value = pop_item.value;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			argb_q <= conv_value;
		end
	end

endmodule

[design/tfa_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for texel_format_to_argb32 and its bind statement.
// Sees only the top-level ports.
module tfa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] argb
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(argb))
		else $error("Stalled result changed or dropped.");

	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("Input stalled with no result waiting.");

	a_stall_from_receiver: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> $past(out_valid && out_stall))
		else $error("Input stalled without a receiver stall before it.");

	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid && !in_stall)
		else $error("Block not empty when leaving reset.");

endmodule

bind texel_format_to_argb32 tfa_checker u_tfa_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.argb(argb)
);
